/* rtl/ldif_pkg.sv */
// ----------------------------------------------------------------------------
// ldif_pkg
// Shared types and constants for the recency-ordered duplicate identifier
// filter.
// ----------------------------------------------------------------------------
package ldif_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
   localparam int COUNT_WIDTH = 8;
   localparam int STAMP_W     = 32;
   localparam int ENTRY_W     = 64 + 64 + COUNT_WIDTH + STAMP_W;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [7:0]  IGNORE_LIMIT_RESET   = 8'd5;
   localparam logic [10:0] CAPACITY_LIMIT_RESET = 11'd1000;

   localparam logic [0:0] CSR_IGNORE_LIMIT   = 1'd0;
   localparam logic [0:0] CSR_CAPACITY_LIMIT = 1'd1;

   localparam logic [1:0] VERDICT_NEW    = 2'd0;
   localparam logic [1:0] VERDICT_SEEN   = 2'd1;
   localparam logic [1:0] VERDICT_IGNORE = 2'd2;

   typedef struct packed {
      logic [63:0] guid_high;
      logic [63:0] guid_low;
   } req_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic [7:0] count_after;
   } rsp_type;

   typedef struct packed {
      logic [63:0]            key_high;
      logic [63:0]            key_low;
      logic [COUNT_WIDTH-1:0] hit_count;
      logic [STAMP_W-1:0]     stamp;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_ctl_type;

endpackage

/* rtl/ldif_table.sv */
// ----------------------------------------------------------------------------
// ldif_table
// Single-port-write, single-port-read entry memory with a registered read.
// ----------------------------------------------------------------------------
module ldif_table
   import ldif_pkg::*;
(
   input  logic        clock,
   input  mem_ctl_type ctl,
   output entry_type   rd_data
);

   entry_type mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      rd_data <= mem[ctl.rd_addr];
   end

endmodule

/* rtl/lru_duplicate_id_filter_core.sv */
// ----------------------------------------------------------------------------
// lru_duplicate_id_filter_core
// Duplicate identifier filter with hit counts and least-recent eviction.
// ----------------------------------------------------------------------------
// Usage: drive req_data and pulse start while busy is low; the identifier is
// taken on that edge and busy rises. One pass reads the occupied entries from
// the entry memory, one per cycle, until a match is found, tracking a match
// and the least recent entry together. A hit then writes the updated entry. A
// miss on a full table evicts the least recent entry by copying the last slot
// into its place, then writes the new entry. After the capacity was lowered,
// each further eviction rescans the remaining entries. busy falls in the cycle
// the result appears, so the next item may start then. The result appears on
// rsp_data for one cycle with rsp_valid high; the receiver cannot stall it.
// Configuration transfers on the csr_ channel are always accepted. Synchronous
// reset empties the table and restores the register defaults; the memory
// itself is not cleared.
// ----------------------------------------------------------------------------
module lru_duplicate_id_filter_core
   import ldif_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_DECIDE= 7'b0000100,
      S_EVRD  = 7'b0001000,
      S_EVWAIT= 7'b0010000,
      S_EVWR  = 7'b0100000,
      S_INSERT= 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   req_type           key_ff, key_in;
   logic [7:0]        ignore_ff, ignore_in;
   logic [10:0]       cap_ff, cap_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [STAMP_W-1:0] clk_ff, clk_in;
   logic [OCC_W-1:0]  idx_ff, idx_in;
   logic              rdv_ff, rdv_in;
   logic [ADDR_W-1:0] rdi_ff, rdi_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] hidx_ff, hidx_in;
   entry_type         hent_ff, hent_in;
   logic [ADDR_W-1:0] vidx_ff, vidx_in;
   logic [STAMP_W-1:0] vage_ff, vage_in;
   logic              rspv_ff, rspv_in;
   rsp_type           rsp_ff, rsp_in;
   mem_ctl_type       ctl;
   entry_type         rd_data;
   logic [OCC_W-1:0]  cap_eff;
   logic [STAMP_W-1:0] age;
   logic [COUNT_WIDTH-1:0] cnt_new;

   ldif_table u_table (.clock(clock), .ctl(ctl), .rd_data(rd_data));

   always_comb begin
      if (cap_ff == 11'd0) begin
         cap_eff = OCC_W'(1);
      end else if ({{(OCC_W > 11 ? OCC_W - 11 : 0){1'b0}}, cap_ff} > OCC_W'(TABLE_DEPTH)) begin
         cap_eff = OCC_W'(TABLE_DEPTH);
      end else begin
         cap_eff = OCC_W'(cap_ff);
      end
   end

   assign age = clk_ff - rd_data.stamp;
   assign cnt_new = (hent_ff.hit_count < COUNT_MAX) ? hent_ff.hit_count + 1'b1
                                                     : hent_ff.hit_count;

   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      ignore_in = ignore_ff;
      cap_in   = cap_ff;
      occ_in   = occ_ff;
      clk_in   = clk_ff;
      idx_in   = idx_ff;
      rdv_in   = 1'b0;
      rdi_in   = rdi_ff;
      hit_in   = hit_ff;
      hidx_in  = hidx_ff;
      hent_in  = hent_ff;
      vidx_in  = vidx_ff;
      vage_in  = vage_ff;
      rspv_in  = 1'b0;
      rsp_in   = rsp_ff;
      ctl      = '0;
      ctl.rd_addr = idx_ff[ADDR_W-1:0];

      if (csr_valid) begin
         case (csr_index)
            CSR_IGNORE_LIMIT:   ignore_in = csr_data[7:0];
            CSR_CAPACITY_LIMIT: cap_in    = csr_data[10:0];
            default: ;
         endcase
      end

      // Scan pipeline: compare the entry read in the previous cycle.
      if (rdv_ff && !hit_ff) begin
         if (rd_data.key_high == key_ff.guid_high && rd_data.key_low == key_ff.guid_low) begin
            hit_in  = 1'b1;
            hidx_in = rdi_ff;
            hent_in = rd_data;
         end
         if (rdi_ff == '0 || age > vage_ff) begin
            vage_in = age;
            vidx_in = rdi_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in   = req_data;
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (idx_ff < occ_ff && !hit_in) begin
               ctl.rd_addr = idx_ff[ADDR_W-1:0];
               rdv_in = 1'b1;
               rdi_in = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff + 1'b1;
            end else if (!rdv_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (hit_ff) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = hidx_ff;
               ctl.wr_data = hent_ff;
               ctl.wr_data.hit_count = cnt_new;
               ctl.wr_data.stamp = clk_ff;
               rsp_in.verdict = ({{(COUNT_WIDTH > 8 ? COUNT_WIDTH - 8 : 0){1'b0}}, ignore_ff}
                                < COUNT_WIDTH'(cnt_new)) ? VERDICT_IGNORE : VERDICT_SEEN;
               rsp_in.count_after = cnt_new[7:0];
               rspv_in  = 1'b1;
               clk_in   = clk_ff + 1'b1;
               state_in = S_IDLE;
            end else if (occ_ff >= cap_eff) begin
               ctl.rd_addr = ADDR_W'(occ_ff - 1'b1);
               state_in = S_EVRD;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_EVRD: begin
            ctl.rd_addr = ADDR_W'(occ_ff - 1'b1);
            state_in = S_EVWAIT;
         end
         S_EVWAIT: begin
            ctl.rd_addr = ADDR_W'(occ_ff - 1'b1);
            state_in = S_EVWR;
         end
         S_EVWR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = vidx_ff;
            ctl.wr_data = rd_data;
            occ_in = occ_ff - 1'b1;
            if (occ_in >= cap_eff) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_addr = occ_ff[ADDR_W-1:0];
            ctl.wr_data.key_high  = key_ff.guid_high;
            ctl.wr_data.key_low   = key_ff.guid_low;
            ctl.wr_data.hit_count = COUNT_WIDTH'(1);
            ctl.wr_data.stamp     = clk_ff;
            occ_in   = occ_ff + 1'b1;
            clk_in   = clk_ff + 1'b1;
            rsp_in.verdict     = VERDICT_NEW;
            rsp_in.count_after = 8'd1;
            rspv_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ignore_ff <= IGNORE_LIMIT_RESET;
         cap_ff    <= CAPACITY_LIMIT_RESET;
         occ_ff    <= '0;
         clk_ff    <= '0;
         rdv_ff    <= 1'b0;
         rspv_ff   <= 1'b0;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ignore_ff <= ignore_in;
         cap_ff    <= cap_in;
         occ_ff    <= occ_in;
         clk_ff    <= clk_in;
         rdv_ff    <= rdv_in;
         rspv_ff   <= rspv_in;
         hit_ff    <= hit_in;
      end
      key_ff  <= key_in;
      idx_ff  <= idx_in;
      rdi_ff  <= rdi_in;
      hidx_ff <= hidx_in;
      hent_ff <= hent_in;
      vidx_ff <= vidx_in;
      vage_ff <= vage_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

endmodule
